// File: src/hpfc_pkg.sv
`default_nettype none

package hpfc_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned HALF_WIDTH = 16;
   localparam int unsigned OP_WIDTH   = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_FP32_TO_FP16 = 2'd0,
      OP_FP16_TO_FP32 = 2'd1,
      OP_FP32_TO_BF16 = 2'd2,
      OP_BF16_TO_FP32 = 2'd3
   } op_type;

   localparam logic [14:0] FP16_INF_MAG    = 15'h7C00;
   localparam logic [7:0]  FP32_EXP_ONES   = 8'hFF;
   localparam logic [4:0]  FP16_EXP_ONES   = 5'h1F;
   localparam logic [7:0]  FP32_BIAS       = 8'd127;
   localparam logic [7:0]  FP16_BIAS       = 8'd15;
   localparam logic [7:0]  EXP_FP16_MAX    = FP32_BIAS + FP16_BIAS;
   localparam logic [7:0]  EXP_FP16_TINY   = FP32_BIAS - 8'd24;
   localparam logic [7:0]  EXP_FP16_NORMAL = FP32_BIAS - 8'd14;
   localparam logic [7:0]  EXP_REBIAS      = FP32_BIAS - FP16_BIAS;
   localparam logic [7:0]  EXP_SUB_BASE    = EXP_REBIAS - 8'd9;
   localparam logic [4:0]  SUB_ROUND_BASE  = 5'd12;
   localparam logic [31:0] BF16_ROUND_BIAS = 32'h0000_7FFF;
   localparam logic [15:0] BF16_QUIET_BIT  = 16'h0040;

endpackage

`default_nettype wire

// File: src/hpfc_convert.sv
`default_nettype none

module hpfc_convert (
   input  hpfc_pkg::op_type                      operation,
   input  logic [hpfc_pkg::WORD_WIDTH-1:0]      operand_bits,
   output logic [hpfc_pkg::WORD_WIDTH-1:0]      result_bits
);
   import hpfc_pkg::*;

   // fp32 source fields
   logic        f_sign;
   logic [7:0]  f_exp;
   logic [22:0] f_frac;
   logic [23:0] f_mant;

   // fp32 to fp16
   logic [7:0]  sub_diff;
   logic [4:0]  sub_rb_pos;
   logic [23:0] sub_at_guard;
   logic [23:0] sub_shifted;
   logic [23:0] sub_mask;
   logic        sub_sticky;
   logic        sub_round;
   logic [10:0] sub_mag;
   logic [7:0]  nrm_exp8;
   logic        nrm_round;
   logic [14:0] nrm_sum;
   logic [9:0]  nan_frac;
   logic [15:0] h_result;

   // fp16 to fp32
   logic        h_sign;
   logic [4:0]  h_exp;
   logic [9:0]  h_frac;
   logic [3:0]  h_lead;
   logic [9:0]  h_norm_frac;
   logic [7:0]  h_norm_exp;
   logic [31:0] w_result;

   // fp32 to bf16
   logic [31:0] bf_sum;
   logic [15:0] bf_result;

   always_comb begin
      f_sign = operand_bits[31];
      f_exp  = operand_bits[30:23];
      f_frac = operand_bits[22:0];
      f_mant = {1'b1, f_frac};

      sub_diff     = EXP_FP16_NORMAL - f_exp;
      sub_rb_pos   = {1'b0, sub_diff[3:0]} + SUB_ROUND_BASE;
      sub_at_guard = f_mant >> sub_rb_pos;
      sub_shifted  = sub_at_guard >> 1;
      sub_mask     = ~(24'hFF_FFFF << sub_rb_pos);
      sub_sticky   = |(f_mant & sub_mask);
      sub_round    = sub_at_guard[0] & (sub_sticky | sub_shifted[0]);
      sub_mag      = sub_shifted[10:0] + {10'd0, sub_round};

      nrm_exp8  = f_exp - EXP_REBIAS;
      nrm_round = f_frac[12] & ((|f_frac[11:0]) | f_frac[13]);
      nrm_sum   = {nrm_exp8[4:0], f_frac[22:13]} + {14'd0, nrm_round};

      nan_frac = f_frac[22:13];
      if (nan_frac == 10'd0) begin
         nan_frac = 10'd1;
      end

      if (f_exp == FP32_EXP_ONES) begin
         if (f_frac == 23'd0) begin
            h_result = {f_sign, FP16_INF_MAG};
         end else begin
            h_result = {f_sign, FP16_EXP_ONES, nan_frac};
         end
      end else if (f_exp > EXP_FP16_MAX) begin
         h_result = {f_sign, FP16_INF_MAG};
      end else if (f_exp < EXP_FP16_TINY) begin
         h_result = {f_sign, 15'd0};
      end else if (f_exp < EXP_FP16_NORMAL) begin
         h_result = {f_sign, 4'd0, sub_mag};
      end else if (nrm_sum >= FP16_INF_MAG) begin
         h_result = {f_sign, FP16_INF_MAG};
      end else begin
         h_result = {f_sign, nrm_sum};
      end

      h_sign = operand_bits[15];
      h_exp  = operand_bits[14:10];
      h_frac = operand_bits[9:0];

      // highest set bit of a subnormal fraction
      h_lead = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h_frac[i]) begin
            h_lead = 4'(i);
         end
      end
      h_norm_frac = h_frac << (4'd10 - h_lead);
      h_norm_exp  = EXP_SUB_BASE + {4'd0, h_lead};

      if (h_exp == 5'd0) begin
         if (h_frac == 10'd0) begin
            w_result = {h_sign, 31'd0};
         end else begin
            w_result = {h_sign, h_norm_exp, h_norm_frac, 13'd0};
         end
      end else if (h_exp == FP16_EXP_ONES) begin
         w_result = {h_sign, FP32_EXP_ONES, h_frac, 13'd0};
      end else begin
         w_result = {h_sign, {3'd0, h_exp} + EXP_REBIAS, h_frac, 13'd0};
      end

      bf_sum = operand_bits + BF16_ROUND_BIAS + {31'd0, operand_bits[16]};
      if (f_exp == FP32_EXP_ONES) begin
         bf_result = operand_bits[31:16];
         if ((f_frac != 23'd0) && (bf_result[6:0] == 7'd0)) begin
            bf_result = bf_result | BF16_QUIET_BIT;
         end
      end else begin
         bf_result = bf_sum[31:16];
      end

      case (operation)
         OP_FP32_TO_FP16: result_bits = {16'd0, h_result};
         OP_FP16_TO_FP32: result_bits = w_result;
         OP_FP32_TO_BF16: result_bits = {16'd0, bf_result};
         OP_BF16_TO_FP32: result_bits = {operand_bits[15:0], 16'd0};
         default:         result_bits = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: src/half_precision_format_converter_top.sv
// Float format converter between fp32, fp16 and bf16.
// Request channel: req_valid with req_operation (0 fp32 to fp16, 1 fp16 to
// fp32, 2 fp32 to bf16, 3 bf16 to fp32) and req_operand_bits; 16-bit
// sources sit in the low half. The block drives req_stall.
// Response channel: rsp_valid with rsp_result_bits; 16-bit results are
// zero-extended. The receiver drives rsp_stall.
// Each item yields exactly one response item, in order.
// An item accepted into the input register passes the conversion and then
// the result register before it is presented on the response channel.
// Throughput: one item per cycle while the response is not stalled, set by
// the single conversion stage between the two registers.
// Stalls: while rsp_stall is high the result register holds its item; the
// input register still fills, and req_stall rises only when both registers
// hold items and the response is stalled.
// Reset (synchronous, active high) empties both registers.
`default_nettype none

module half_precision_format_converter_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [hpfc_pkg::OP_WIDTH-1:0]        req_operation,
   input  logic [hpfc_pkg::WORD_WIDTH-1:0]      req_operand_bits,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hpfc_pkg::WORD_WIDTH-1:0]      rsp_result_bits
);
   import hpfc_pkg::*;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   op_type                in_op_ff;
   logic [WORD_WIDTH-1:0] in_bits_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [WORD_WIDTH-1:0] out_bits_ff;
   logic [WORD_WIDTH-1:0] conv_bits;
   logic                  out_free;
   logic                  take_item;
   logic                  move_item;

   hpfc_convert u_convert (
      .operation    (in_op_ff),
      .operand_bits (in_bits_ff),
      .result_bits  (conv_bits)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign take_item = req_valid && !req_stall;
   assign move_item = in_valid_ff && out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_item) begin
         in_valid_in = 1'b1;
      end else if (move_item) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (move_item) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_item) begin
         in_op_ff   <= op_type'(req_operation);
         in_bits_ff <= req_operand_bits;
      end
      if (move_item) begin
         out_bits_ff <= conv_bits;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_bits = out_bits_ff;

endmodule

`default_nettype wire
